/* hdl/rsca_pkg.sv */
// Shared types, widths and constants for the ray/sphere chord accumulator.
// No dependencies; every other file of the block imports this package.
package rsca_pkg;

    localparam int POS_W      = 32;   // signed Q16.16 coordinates
    localparam int RADIUS_W   = 31;   // unsigned Q15.16 radius
    localparam int ANG_W      = 16;   // angle, 65536 = one full turn
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int W_W        = POS_W + 1;   // position minus center
    localparam int ROT_W      = 34;   // CORDIC x, y and z registers
    localparam int STEP_W     = 5;
    localparam int CORDIC_STEPS = 30;
    localparam int MUL_W      = 36;   // signed multiplier operand
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = 66;   // dot product accumulator
    localparam int SQ_W       = 68;   // sums of squares
    localparam int ROOT_W     = 35;   // square root result bits
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int CNT_W      = 6;
    localparam int CHORD_W    = 32;
    localparam int TOTAL_W    = 48;
    localparam int H_SHIFT    = 28;   // Q44 dot product down to Q16

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS   = 2'd0,
        REG_CENTER_X = 2'd1,
        REG_CENTER_Y = 2'd2,
        REG_CENTER_Z = 2'd3
    } t_cfg_idx;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic                    considered;
        logic signed [W_W-1:0]   wx;
        logic signed [W_W-1:0]   wy;
        logic signed [W_W-1:0]   wz;
        logic [ANG_W-1:0]        polar;
        logic [ANG_W-1:0]        azimuth;
    } t_item;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [ROT_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic signed [ROT_W-1:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458908;
            5'd3:  v = 34'sd85004758;
            5'd4:  v = 34'sd42667330;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679842;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/rsca_front.sv */
// Front end: accepts input items, classifies them and forms position minus center.
// Depends on rsca_pkg.
module rsca_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [rsca_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [rsca_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [rsca_pkg::POS_W-1:0]  i_pos_z,
    input  logic [rsca_pkg::ANG_W-1:0]         i_polar_angle,
    input  logic [rsca_pkg::ANG_W-1:0]         i_azimuth_angle,
    input  logic                               i_absorbed,
    input  logic signed [rsca_pkg::POS_W-1:0]  i_center_x,
    input  logic signed [rsca_pkg::POS_W-1:0]  i_center_y,
    input  logic signed [rsca_pkg::POS_W-1:0]  i_center_z,
    input  logic                               i_full,
    output logic                               o_push,
    output rsca_pkg::t_item                    o_item
);
    import rsca_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_comb begin
        n_item.considered = !i_absorbed && !i_pos_x[POS_W-1];
        n_item.wx = W_W'(i_pos_x) - W_W'(i_center_x);
        n_item.wy = W_W'(i_pos_y) - W_W'(i_center_y);
        n_item.wz = W_W'(i_pos_z) - W_W'(i_center_z);
        n_item.polar   = i_polar_angle;
        n_item.azimuth = i_azimuth_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

/* hdl/rsca_queue.sv */
// Two-entry queue of classified items between the front and the back.
// Depends on rsca_pkg.
module rsca_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsca_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output rsca_pkg::t_item o_item
);
    import rsca_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

/* hdl/rsca_back.sv */
// Back end: CORDIC sine/cosine, shared multiplier, discriminant, square root
// and the saturating total, with the output register. Depends on rsca_pkg.
module rsca_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  rsca_pkg::t_item                      i_item,
    output logic                                 o_pop,
    input  logic [rsca_pkg::RADIUS_W-1:0]        i_radius,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_considered,
    output logic                                 o_hit,
    output logic [rsca_pkg::CHORD_W-1:0]         o_chord_length,
    output logic [rsca_pkg::TOTAL_W-1:0]         o_total_length
);
    import rsca_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ROT, S_FIX, S_MUL, S_SUM, S_HRND, S_CMP, S_ROOT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        MS_RR, MS_WXX, MS_WYY, MS_WZZ, MS_STCP, MS_STSP,
        MS_DXWX, MS_DYWY, MS_DZWZ, MS_HH
    } t_mul_step;

    t_state     r_state;
    t_mul_step  r_step;
    t_item      r_item;
    logic [CNT_W-1:0] r_cnt;

    logic signed [ROT_W-1:0] r_xt, r_yt, r_zt, r_xp, r_yp, r_zp;
    logic r_negt, r_negp;

    logic signed [MUL_W-1:0]  r_st, r_sp, r_cp, r_dx, r_dy, r_dz, r_h;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_s;
    logic [SQ_W-1:0]          r_r2, r_rhs, r_lhs;
    logic [RAD_W-1:0]         r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic                     r_hit;
    logic [CHORD_W-1:0]       r_chord;

    logic                     r_out_valid;
    logic                     r_out_considered;
    logic                     r_out_hit;
    logic [CHORD_W-1:0]       r_out_chord;
    logic [TOTAL_W-1:0]       r_total;

    // Angle fold into [-1/4, 1/4) turn for both angles.
    logic [31:0] ang_t, ang_p;
    logic        fold_t, fold_p;
    // One CORDIC iteration for each angle.
    logic signed [ROT_W-1:0] xs_t, ys_t, xs_p, ys_p, atan_i;
    // Multiplier operands.
    logic signed [MUL_W-1:0] mul_a, mul_b;
    // Root step.
    logic [REM_W-1:0] rem_sh, trial;
    logic             root_ge;
    logic signed [SUM_W-1:0] s_rnd;
    logic [TOTAL_W:0] total_sum;

    assign o_pop          = (r_state == S_IDLE) && !i_empty;
    assign o_valid        = r_out_valid;
    assign o_considered   = r_out_considered;
    assign o_hit          = r_out_hit;
    assign o_chord_length = r_out_chord;
    assign o_total_length = r_total;

    always_comb begin
        ang_t  = {i_item.polar, 16'h0000};
        ang_p  = {i_item.azimuth, 16'h0000};
        fold_t = ang_t[31] ^ ang_t[30];
        fold_p = ang_p[31] ^ ang_p[30];
        if (fold_t) begin
            ang_t[31] = !ang_t[31];
        end
        if (fold_p) begin
            ang_p[31] = !ang_p[31];
        end

        xs_t   = r_xt >>> r_cnt[STEP_W-1:0];
        ys_t   = r_yt >>> r_cnt[STEP_W-1:0];
        xs_p   = r_xp >>> r_cnt[STEP_W-1:0];
        ys_p   = r_yp >>> r_cnt[STEP_W-1:0];
        atan_i = atan_turn(r_cnt[STEP_W-1:0]);

        case (r_step)
            MS_RR:   begin mul_a = MUL_W'({1'b0, i_radius}); mul_b = mul_a; end
            MS_WXX:  begin mul_a = MUL_W'(r_item.wx); mul_b = mul_a; end
            MS_WYY:  begin mul_a = MUL_W'(r_item.wy); mul_b = mul_a; end
            MS_WZZ:  begin mul_a = MUL_W'(r_item.wz); mul_b = mul_a; end
            MS_STCP: begin mul_a = r_st; mul_b = r_cp; end
            MS_STSP: begin mul_a = r_st; mul_b = r_sp; end
            MS_DXWX: begin mul_a = r_dx; mul_b = MUL_W'(r_item.wx); end
            MS_DYWY: begin mul_a = r_dy; mul_b = MUL_W'(r_item.wy); end
            MS_DZWZ: begin mul_a = r_dz; mul_b = MUL_W'(r_item.wz); end
            MS_HH:   begin mul_a = r_h; mul_b = r_h; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase

        rem_sh  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial   = {{(REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
        root_ge = (rem_sh >= trial);

        s_rnd     = r_s + (SUM_W'(1) <<< (H_SHIFT - 1));
        total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(r_chord);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= MS_RR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            // A result taken while a new one is loaded is handled in S_DONE.
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_item;
                        r_hit   <= 1'b0;
                        r_chord <= '0;
                        r_cnt   <= '0;
                        r_step  <= MS_RR;
                        r_xt    <= CORDIC_GAIN;
                        r_xp    <= CORDIC_GAIN;
                        r_yt    <= '0;
                        r_yp    <= '0;
                        r_zt    <= ROT_W'($signed(ang_t));
                        r_zp    <= ROT_W'($signed(ang_p));
                        r_negt  <= fold_t;
                        r_negp  <= fold_p;
                        r_state <= i_item.considered ? S_ROT : S_DONE;
                    end
                end
                S_ROT: begin
                    if (!r_zt[ROT_W-1]) begin
                        r_xt <= r_xt - ys_t; r_yt <= r_yt + xs_t; r_zt <= r_zt - atan_i;
                    end else begin
                        r_xt <= r_xt + ys_t; r_yt <= r_yt - xs_t; r_zt <= r_zt + atan_i;
                    end
                    if (!r_zp[ROT_W-1]) begin
                        r_xp <= r_xp - ys_p; r_yp <= r_yp + xs_p; r_zp <= r_zp - atan_i;
                    end else begin
                        r_xp <= r_xp + ys_p; r_yp <= r_yp - xs_p; r_zp <= r_zp + atan_i;
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // Undo the half-turn fold, then cos(theta) in Q2.28 is z of d.
                    r_st <= MUL_W'(r_negt ? -r_yt : r_yt);
                    r_dz <= MUL_W'(r_negt ? -r_xt : r_xt) >>> 2;
                    r_sp <= MUL_W'(r_negp ? -r_yp : r_yp);
                    r_cp <= MUL_W'(r_negp ? -r_xp : r_xp);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_step  <= t_mul_step'(r_step + 4'd1);
                    // The dot product is rounded before h*h; h*h ends the sequence.
                    r_state <= (r_step == MS_DZWZ) ? S_HRND :
                               (r_step == MS_HH)   ? S_CMP  :
                               (r_step > MS_HH)    ? S_IDLE : S_MUL;
                    case (r_step)
                        MS_RR:   r_r2  <= r_prod[SQ_W-1:0];
                        MS_WXX:  r_rhs <= r_prod[SQ_W-1:0];
                        MS_WYY:  r_rhs <= r_rhs + r_prod[SQ_W-1:0];
                        MS_WZZ:  r_rhs <= r_rhs + r_prod[SQ_W-1:0];
                        MS_STCP: r_dx  <= r_prod[MUL_W+31:32];
                        MS_STSP: r_dy  <= r_prod[MUL_W+31:32];
                        MS_DXWX: r_s   <= r_prod[SUM_W-1:0];
                        MS_DYWY: r_s   <= r_s + r_prod[SUM_W-1:0];
                        MS_DZWZ: r_s   <= r_s + r_prod[SUM_W-1:0];
                        MS_HH:   r_lhs <= r_prod[SQ_W-1:0] + r_r2;
                        default: ;
                    endcase
                end
                S_HRND: begin
                    r_h     <= s_rnd[MUL_W+H_SHIFT-1:H_SHIFT];
                    r_state <= S_MUL;
                end
                S_CMP: begin
                    r_cnt  <= '0;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_rad  <= RAD_W'(r_lhs - r_rhs) << 2;
                    if (r_lhs > r_rhs) begin
                        r_hit   <= 1'b1;
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ROOT: begin
                    r_rad <= r_rad << 2;
                    if (root_ge) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(ROOT_W)) begin
                        // The root is complete; clamp it to the chord width.
                        r_chord <= (|r_root[ROOT_W-1:CHORD_W]) ? '1 : r_root[CHORD_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid      <= 1'b1;
                        r_out_considered <= r_item.considered;
                        r_out_hit        <= r_hit;
                        r_out_chord      <= r_chord;
                        if (r_hit) begin
                            r_total <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/ray_sphere_chord_accumulator.sv */
// Top level of the ray/sphere chord accumulator: configuration registers,
// front end, item queue and back end. Depends on rsca_pkg and its submodules.
//
//   Channel   Signals                                   Direction  Handshake
//   input     i_pos_x/y/z, i_polar_angle,               in         i_valid / o_ready
//             i_azimuth_angle, i_absorbed
//   result    o_considered, o_hit, o_chord_length,      out        o_valid / i_ready
//             o_total_length
//   config    i_cfg_we, i_cfg_idx, i_cfg_data           in         write enable only
//
// A considered item that hits passes through the back end in order: it is taken
// from the queue, both angles go through the CORDIC iterations at once, the fold
// is undone, ten products go through one shared 36x36 multiplier with rounding
// before the last; a compare, the digit-by-digit square root and the result load
// follow. A miss skips the square root; an unconsidered item skips all but the load.
// Reset is synchronous and active low; it restores radius 1.0, center at the
// origin and a zero running total. The front end keeps taking items into the
// two-entry queue while the back end works or while a result waits unread.
module ray_sphere_chord_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [rsca_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [rsca_pkg::POS_W-1:0]     i_pos_y,
    input  logic signed [rsca_pkg::POS_W-1:0]     i_pos_z,
    input  logic [rsca_pkg::ANG_W-1:0]            i_polar_angle,
    input  logic [rsca_pkg::ANG_W-1:0]            i_azimuth_angle,
    input  logic                                  i_absorbed,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_considered,
    output logic                                  o_hit,
    output logic [rsca_pkg::CHORD_W-1:0]          o_chord_length,
    output logic [rsca_pkg::TOTAL_W-1:0]          o_total_length,
    input  logic                                  i_cfg_we,
    input  logic [rsca_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rsca_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import rsca_pkg::*;

    // Sphere parameters: user must change them only while the block is idle, unenforced.
    logic [RADIUS_W-1:0]     r_radius;
    logic signed [POS_W-1:0] r_center_x;
    logic signed [POS_W-1:0] r_center_y;
    logic signed [POS_W-1:0] r_center_z;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_item front_item;
    t_item head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_W'(32'h0001_0000);
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_RADIUS:   r_radius   <= i_cfg_data[RADIUS_W-1:0];
                REG_CENTER_X: r_center_x <= i_cfg_data;
                REG_CENTER_Y: r_center_y <= i_cfg_data;
                REG_CENTER_Z: r_center_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front end classifies each item and subtracts the sphere center.
    rsca_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_polar_angle   (i_polar_angle),
        .i_azimuth_angle (i_azimuth_angle),
        .i_absorbed      (i_absorbed),
        .i_center_x      (r_center_x),
        .i_center_y      (r_center_y),
        .i_center_z      (r_center_z),
        .i_full          (full),
        .o_push          (push),
        .o_item          (front_item)
    );

    // The queue lets the front keep accepting while the back is busy.
    rsca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item)
    );

    // The back end runs the arithmetic sequence and owns the result register.
    rsca_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (head_item),
        .o_pop          (pop),
        .i_radius       (r_radius),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_considered   (o_considered),
        .o_hit          (o_hit),
        .o_chord_length (o_chord_length),
        .o_total_length (o_total_length)
    );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the ray/sphere chord accumulator.
// Depends on rsca_pkg and ray_sphere_chord_accumulator from the hdl folder.
module tb;

    import rsca_pkg::*;

    localparam int         RUN_LIMIT  = 3000000;
    localparam int         DRAIN_WAIT = 200;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

    // One particle as offered on the input channel.
    typedef struct {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [ANG_W-1:0]        polar;
        logic [ANG_W-1:0]        azim;
        logic                    absorbed;
    } t_particle;

    // The outcome the block must report for one particle.
    typedef struct {
        logic               considered;
        logic               hit;
        logic [CHORD_W-1:0] chord;
        logic [TOTAL_W-1:0] total;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [ANG_W-1:0]      i_polar_angle = '0, i_azimuth_angle = '0;
    logic                  i_absorbed = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_considered, o_hit;
    logic [CHORD_W-1:0]    o_chord_length;
    logic [TOTAL_W-1:0]    o_total_length;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the block's registers and running total.
    logic [RADIUS_W-1:0]     radius_q;
    logic signed [POS_W-1:0] ctr_x, ctr_y, ctr_z;
    logic [TOTAL_W-1:0]      path_sum;

    t_outcome pending_outcomes[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       hits_seen = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       recv_hold = 0;

    ray_sphere_chord_accumulator DUT (.*);

    always begin
        #10 i_clk = ~i_clk;
    end

    // Watchdog: a hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver side: a long hold-off wins over the random stall rate.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            i_ready   = 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            i_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Arctangent of 2^-i in units of 2^-32 turn, used by the CORDIC below.
    function automatic longint atan_step(input int i);
        longint tbl[30] = '{
            536870912, 316933406, 167458908, 85004758, 42667330, 21354465,
            10679842, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1};
        return tbl[i];
    endfunction

    // Sine and cosine in Q1.30 of an angle given as a fraction of a turn.
    // The angle is folded into the right half plane first, then rotated.
    function automatic void sin_cos(input logic [ANG_W-1:0] ang,
                                    output longint s, output longint c);
        logic [31:0] a;
        logic [31:0] probe;
        logic        flip;
        longint      x, y, z, xs, ys;
        a     = {ang, 16'h0000};
        probe = a + 32'h4000_0000;
        flip  = probe[31];
        if (flip) begin
            a[31] = ~a[31];
        end
        z = $signed(a);
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end else begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // Works out the chord for one particle and advances the shadow total.
    function automatic t_outcome chord_of(input t_particle p);
        t_outcome               res;
        longint                 st, ct, sp, cp, dx, dy, dz, wx, wy, wz, dotp, h;
        logic signed [127:0]    h2, wx2, wy2, wz2, rr;
        logic [127:0]           lhs, rhs, disc, sq;
        logic [63:0]            root, cand;
        res.considered = !p.absorbed && !p.px[POS_W-1];
        res.hit        = 1'b0;
        res.chord      = '0;
        if (res.considered) begin
            sin_cos(p.polar, st, ct);
            sin_cos(p.azim, sp, cp);
            dx   = (st * cp) >>> 32;
            dy   = (st * sp) >>> 32;
            dz   = ct >>> 2;
            wx   = longint'(p.px) - longint'(ctr_x);
            wy   = longint'(p.py) - longint'(ctr_y);
            wz   = longint'(p.pz) - longint'(ctr_z);
            dotp = dx * wx + dy * wy + dz * wz;
            h    = (dotp + (longint'(1) << 27)) >>> 28;
            h2   = h;
            wx2  = wx;
            wy2  = wy;
            wz2  = wz;
            rr   = {97'b0, radius_q};
            lhs  = h2 * h2 + rr * rr;
            rhs  = wx2 * wx2 + wy2 * wy2 + wz2 * wz2;
            if (lhs > rhs) begin
                disc = (lhs - rhs) << 2;
                root = '0;
                for (int b = 40; b >= 0; b--) begin
                    cand = root | (64'd1 << b);
                    sq   = {64'b0, cand} * {64'b0, cand};
                    if (sq <= disc) begin
                        root = cand;
                    end
                end
                if (root > 64'hFFFF_FFFF) begin
                    root = 64'hFFFF_FFFF;
                end
                res.hit   = 1'b1;
                res.chord = root[31:0];
                if ({16'b0, root[31:0]} > {16'b0, TOTAL_MAX - path_sum}) begin
                    path_sum = TOTAL_MAX;
                end else begin
                    path_sum = path_sum + root[31:0];
                end
            end
        end
        res.total = path_sum;
        return res;
    endfunction

    // Result checker: each accepted result is matched against the oldest outcome.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                $error("Result arrived with no item outstanding");
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_hit) hits_seen++;
                if (o_considered !== want.considered) begin
                    $error("considered: expected %0d, got %0d", want.considered, o_considered);
                    error_count++;
                end
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    error_count++;
                end
                if (o_chord_length !== want.chord) begin
                    $error("chord_length: expected %h, got %h", want.chord, o_chord_length);
                    error_count++;
                end
                if (o_total_length !== want.total) begin
                    $error("total_length: expected %h, got %h", want.total, o_total_length);
                    error_count++;
                end
            end
        end
    end

    // Offers one item, honoring the sender idle rate, and waits for acceptance.
    task automatic send_particle(input t_particle p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_pos_x         = p.px;
        i_pos_y         = p.py;
        i_pos_z         = p.pz;
        i_polar_angle   = p.polar;
        i_azimuth_angle = p.azim;
        i_absorbed      = p.absorbed;
        i_valid         = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_outcomes.push_back(chord_of(p));
        items_sent++;
    endtask

    // Lowers valid and waits until every outstanding result has come back.
    task automatic drain;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Register write while the block is idle; the shadow copy follows it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            REG_RADIUS:   radius_q = data[RADIUS_W-1:0];
            REG_CENTER_X: ctr_x    = data;
            REG_CENTER_Y: ctr_y    = data;
            REG_CENTER_Z: ctr_z    = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_sphere(input logic [31:0] r, input logic [31:0] cx,
                              input logic [31:0] cy, input logic [31:0] cz);
        write_reg(REG_RADIUS, r);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
    endtask

    function automatic t_particle mk(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic [15:0] th,
                                     input logic [15:0] ph, input logic ab);
        t_particle p;
        p.px = x; p.py = y; p.pz = z;
        p.polar = th; p.azim = ph; p.absorbed = ab;
        return p;
    endfunction

    // Random particle: mostly near the sphere so that hits are common, some
    // with fully random coordinates and a few absorbed or at negative x.
    function automatic t_particle random_particle;
        t_particle p;
        int        span;
        int        pick;
        pick = $urandom_range(99);
        span = (radius_q > 0) ? int'(radius_q[30:0] >> 1) + 1 : 65536;
        if (span > 32'h0FFF_FFFF) span = 32'h0FFF_FFFF;
        if (pick < 20) begin
            p.px = $urandom; p.py = $urandom; p.pz = $urandom;
        end else begin
            p.px = ctr_x + $signed($urandom_range(4 * span)) - 2 * span;
            p.py = ctr_y + $signed($urandom_range(4 * span)) - 2 * span;
            p.pz = ctr_z + $signed($urandom_range(4 * span)) - 2 * span;
        end
        p.polar    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        p.azim     = 16'($urandom);
        p.absorbed = ($urandom_range(9) == 0);
        return p;
    endfunction

    // Extremes of every field, the tangent case, a saturated chord and
    // polar angles past half a turn.
    task automatic test_directed;
        set_sphere(32'd65536, 32'd0, 32'd0, 32'd0);
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0));
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'd16384, 16'd0, 1'b1));
        send_particle(mk(32'hFFFF_0000, 32'd0, 32'd0, 16'd16384, 16'd0, 1'b0));
        send_particle(mk(32'd0, 32'd65536, 32'd0, 16'd16384, 16'd0, 1'b0));
        send_particle(mk(32'd0, 32'd131072, 32'd0, 16'd16384, 16'd0, 1'b0));
        send_particle(mk(32'd32768, 32'd0, 32'd0, 16'd32768, 16'd16384, 1'b0));
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'd40000, 16'd49152, 1'b0));
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0));
        send_particle(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd8192, 16'd8192, 1'b0));
        send_particle(mk(32'h0, 32'h8000_0000, 32'h8000_0000, 16'd24576, 16'd40960, 1'b0));
        send_particle(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0));
        set_sphere(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0));
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'd16384, 16'd32768, 1'b0));
        send_particle(mk(32'h7FFF_FFFF, 32'd0, 32'd0, 16'd16384, 16'd0, 1'b0));
        set_sphere(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'd12000, 16'd5000, 1'b0));
        send_particle(mk(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd16384, 16'd32768, 1'b0));
        set_sphere(32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_particle(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd3000, 16'd60000, 1'b0));
        send_particle(mk(32'd0, 32'd0, 32'd0, 16'd16384, 16'd0, 1'b0));
        drain();
    endtask

    // Random sphere per phase; each phase runs with one idling pattern.
    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        logic [31:0] r;
        case ($urandom_range(3))
            0: r = $urandom_range(1 << 20);
            1: r = $urandom_range(32'h0100_0000);
            2: r = $urandom & 32'h7FFF_FFFF;
            default: r = 32'd65536;
        endcase
        set_sphere(r, $urandom, $urandom, $urandom);
        if ($urandom_range(1)) begin
            set_sphere(r, $urandom_range(1 << 22), 32'($urandom_range(1 << 22)) - (1 << 21),
                       32'($urandom_range(1 << 22)) - (1 << 21));
        end
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_particle(random_particle());
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // queue fills and the input stalls; then the sender waits for a full drain.
    task automatic test_backpressure;
        set_sphere(32'd200000, 32'd100000, 32'd0, 32'd0);
        @(negedge i_clk);
        recv_hold = 1500;
        repeat (10) send_particle(random_particle());
        drain();
    endtask

    initial begin
        radius_q = 31'd65536;
        ctr_x    = '0;
        ctr_y    = '0;
        ctr_z    = '0;
        path_sum = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_phase(110, 0, 0);
        test_random_phase(100, 78, 0);
        test_random_phase(100, 0, 78);
        test_random_phase(100, 30, 30);
        test_backpressure();

        $display("Covered %0d items and %0d results (%0d hits) over several sphere settings,",
                 items_sent, results_seen, hits_seen);
        $display("with sender gaps, receiver stalls and a long receiver hold-off.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* ray_sphere_chord_accumulator.f */
hdl/rsca_pkg.sv
hdl/rsca_front.sv
hdl/rsca_queue.sv
hdl/rsca_back.sv
hdl/ray_sphere_chord_accumulator.sv
dv/tb.sv
